// ===== design/plist_pkg.sv =====
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STAT_W   = 2;
    localparam int AT_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_POS  = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_INS_TAIL = 3'd2,
        OP_REM_POS  = 3'd3,
        OP_REM_HEAD = 3'd4,
        OP_REM_TAIL = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [AT_W-1:0]          at;
        logic signed [WORD_W-1:0] word;
    } plist_cmd_t;

endpackage

// ===== design/plist_req_if.sv =====
// ----------------------------------------------------------------------------
// plist_req_if
// Request channel: operation, position and word to insert.
// ----------------------------------------------------------------------------
interface plist_req_if import plist_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

// ===== design/plist_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plist_rsp_if
// Response channel: removed word, status and entry count.
// ----------------------------------------------------------------------------
interface plist_rsp_if import plist_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] removed_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;

    modport source (output valid, output removed_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input entry_count, output ready);
endinterface

// ===== design/plist_cell.sv =====
// ----------------------------------------------------------------------------
// plist_cell
// One list slot. Shifts toward the tail on insert, toward the head on remove.
// ----------------------------------------------------------------------------
module plist_cell import plist_pkg::*;
(
    input  logic                     clk,
    input  plist_cmd_t               cmd,
    input  logic [AT_W-1:0]          index,
    input  logic signed [WORD_W-1:0] left_data,
    input  logic signed [WORD_W-1:0] right_data,
    output logic signed [WORD_W-1:0] data
);

    logic signed [WORD_W-1:0] entry_reg;
    logic signed [WORD_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (index > cmd.at)
                entry_next = left_data;
            else if (index == cmd.at)
                entry_next = cmd.word;
        end
        else if (cmd.rem)
        begin
            if (index >= cmd.at)
                entry_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

// ===== design/plist_ctrl.sv =====
// ----------------------------------------------------------------------------
// plist_ctrl
// Decodes one word, checks bounds, keeps the entry count, drives the cells.
// ----------------------------------------------------------------------------
module plist_ctrl import plist_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [OP_W-1:0]          operation,
    input  logic [POS_W-1:0]         position,
    input  logic signed [WORD_W-1:0] value,
    output plist_cmd_t               cmd,
    output status_t                  status,
    output logic [CNT_W-1:0]         count_next
);

    logic [CNT_W-1:0] count_reg;
    logic [AT_W-1:0]  count_ext;
    logic [AT_W-1:0]  pos_ext;
    logic [AT_W-1:0]  at;
    logic             is_ins;
    logic             is_rem;
    logic             ok;

    assign count_ext = AT_W'(count_reg);
    assign pos_ext   = AT_W'(position);

    always_comb
    begin
        is_ins = 1'b0;
        is_rem = 1'b0;
        at     = '0;
        unique case (op_t'(operation))
            OP_INS_POS:  begin is_ins = 1'b1; at = pos_ext;           end
            OP_INS_HEAD: begin is_ins = 1'b1; at = '0;                end
            OP_INS_TAIL: begin is_ins = 1'b1; at = count_ext;         end
            OP_REM_POS:  begin is_rem = 1'b1; at = pos_ext;           end
            OP_REM_HEAD: begin is_rem = 1'b1; at = '0;                end
            OP_REM_TAIL: begin is_rem = 1'b1; at = count_ext - 1'b1;  end
            default:     ;
        endcase
    end

    always_comb
    begin
        status = ST_DONE;
        if (is_ins)
        begin
            priority if (at > count_ext)
                status = ST_RANGE;
            else if (count_ext >= AT_W'(CAPACITY))
                status = ST_FULL;
            else
                status = ST_DONE;
        end
        else if (is_rem)
        begin
            priority if (count_reg == '0)
                status = ST_EMPTY;
            else if (at >= count_ext)
                status = ST_RANGE;
            else
                status = ST_DONE;
        end
    end

    assign ok = (status == ST_DONE);

    always_comb
    begin
        cmd.ins  = accept && is_ins && ok;
        cmd.rem  = accept && is_rem && ok;
        cmd.at   = at;
        cmd.word = value;
    end

    always_comb
    begin
        count_next = count_reg;
        if (is_ins && ok)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (is_rem && ok)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

endmodule

// ===== design/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list with insert/remove at position, head or tail.
// ----------------------------------------------------------------------------
// Takes one request word per clock while the sink keeps up and returns one
// response word for each from the output register, in the cycle after the
// request is taken. The list lives in a row of CAPACITY cells that all shift
// by one place in the same cycle, so every operation completes in the cycle
// in which it is taken; a new request enters in the same cycle that the sink
// takes the previous response, and requests stall while a response waits.
// The list contents have no reset; only the entry count and response valid are cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_unit import plist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    plist_req_if.sink   req,
    plist_rsp_if.source rsp
);

    plist_cmd_t               cmd;
    status_t                  status;
    logic [CNT_W-1:0]         count_next;
    logic                     accept;
    logic signed [WORD_W-1:0] cell_data [CAPACITY];
    logic signed [WORD_W-1:0] removed;

    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] removed_reg;
    status_t                  status_reg;
    logic [CNT_W-1:0]         count_out_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    plist_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (req.operation),
        .position   (req.position),
        .value      (req.value),
        .cmd        (cmd),
        .status     (status),
        .count_next (count_next)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_d;
        logic signed [WORD_W-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = cmd.word;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        plist_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .index      (AT_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    assign removed = cmd.rem ? cell_data[cmd.at[IDX_W-1:0]] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg   <= removed;
            status_reg    <= status;
            count_out_reg <= count_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.status        = status_reg;
    assign rsp.entry_count   = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> count_next <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_EMPTY) |-> count_out_reg == '0)
        else $error("empty status with nonzero count");

    a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> count_out_reg == CNT_W'(CAPACITY))
        else $error("full status below capacity");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_DONE) |-> removed_reg == '0)
        else $error("failed operation returned a word");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp.ready && !accept) |=> !out_valid_reg)
        else $error("response not released");

endmodule
